### sv/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants for the pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned OPND_W = 12;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned PROD_W = CH_W + OPND_W;
    localparam int unsigned LAT    = 4;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_MODE  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_RED   = 8'd1;
    localparam logic [IDX_W-1:0] CFG_GREEN = 8'd2;
    localparam logic [IDX_W-1:0] CFG_BLUE  = 8'd3;

    typedef enum logic [2:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SUBTRACT = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_OVERLAY  = 3'd3,
        MODE_ADD      = 3'd4,
        MODE_SCALE    = 3'd5
    } blend_mode_t;

    // how the last stage turns the product, or the side value, into a channel value
    typedef enum logic [1:0] {
        KIND_DIV   = 2'd0,
        KIND_INV   = 2'd1,
        KIND_SCALE = 2'd2,
        KIND_SIDE  = 2'd3
    } post_kind_t;

endpackage

### sv/pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// pixel_blend_unit
// Blends a top and a bottom RGB pixel per channel: multiply, subtract,
// screen, overlay, add or scale, selected by the mode register.
//
//  port group   dir  width        notes
//  start/busy   in   6 x 8        one pixel beat: top_* and bottom_*
//  done         out  3 x 8        one result beat: out_*, one cycle wide
//  cfg_*        in   8 idx, 12    register write, no read-back
//
//  A beat is taken on every cycle with start high; busy never rises.
//  Results appear on done in order of acceptance, one per cycle.
//  Latency is set by the four register stages of each channel datapath.
//  Reset clears the valid pipeline and all configuration registers.
// ----------------------------------------------------------------------------
module pixel_blend_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pbu_pkg::CH_W-1:0]         top_red,
    input  logic [pbu_pkg::CH_W-1:0]         top_green,
    input  logic [pbu_pkg::CH_W-1:0]         top_blue,
    input  logic [pbu_pkg::CH_W-1:0]         bottom_red,
    input  logic [pbu_pkg::CH_W-1:0]         bottom_green,
    input  logic [pbu_pkg::CH_W-1:0]         bottom_blue,
    output logic                             done,
    output logic [pbu_pkg::CH_W-1:0]         out_red,
    output logic [pbu_pkg::CH_W-1:0]         out_green,
    output logic [pbu_pkg::CH_W-1:0]         out_blue,
    input  logic                             cfg_write,
    input  logic [pbu_pkg::IDX_W-1:0]        cfg_index,
    input  logic [pbu_pkg::OPND_W-1:0]       cfg_data
);
    import pbu_pkg::*;

    blend_mode_t       mode_reg;
    logic [OPND_W-1:0] red_opnd_reg;
    logic [OPND_W-1:0] green_opnd_reg;
    logic [OPND_W-1:0] blue_opnd_reg;
    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_MULTIPLY;
            red_opnd_reg   <= '0;
            green_opnd_reg <= '0;
            blue_opnd_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg       <= blend_mode_t'(cfg_data[2:0]);
                CFG_RED:   red_opnd_reg   <= cfg_data;
                CFG_GREEN: green_opnd_reg <= cfg_data;
                CFG_BLUE:  blue_opnd_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[LAT-1];

    pbu_channel u_red (
        .clk     (clk),
        .mode    (mode_reg),
        .top     (top_red),
        .bottom  (bottom_red),
        .operand (red_opnd_reg),
        .result  (out_red)
    );

    pbu_channel u_green (
        .clk     (clk),
        .mode    (mode_reg),
        .top     (top_green),
        .bottom  (bottom_green),
        .operand (green_opnd_reg),
        .result  (out_green)
    );

    pbu_channel u_blue (
        .clk     (clk),
        .mode    (mode_reg),
        .top     (top_blue),
        .bottom  (bottom_blue),
        .operand (blue_opnd_reg),
        .result  (out_blue)
    );

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("accepted beat did not produce a result");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without an accepted beat");

    a_subtract: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode_reg, 4) == MODE_SUBTRACT)
        |-> (out_red <= $past(bottom_red, 4)))
        else $error("subtract result exceeds bottom channel");

endmodule

### sv/pbu_channel.sv
// ----------------------------------------------------------------------------
// pbu_channel
// Four-stage blend datapath for one color channel: operand select,
// multiply, divide-by-255 estimate, correction, inversion and clamp.
// ----------------------------------------------------------------------------
module pbu_channel (
    input  logic                            clk,
    input  pbu_pkg::blend_mode_t            mode,
    input  logic [pbu_pkg::CH_W-1:0]        top,
    input  logic [pbu_pkg::CH_W-1:0]        bottom,
    input  logic [pbu_pkg::OPND_W-1:0]      operand,
    output logic [pbu_pkg::CH_W-1:0]        result
);
    import pbu_pkg::*;

    logic [CH_W-1:0]   s1_a_next;
    logic [OPND_W-1:0] s1_m_next;
    post_kind_t        s1_kind_next;
    logic [CH_W-1:0]   s1_side_next;
    logic [OPND_W:0]   add_sum;

    logic [CH_W-1:0]   s1_a_reg;
    logic [OPND_W-1:0] s1_m_reg;
    post_kind_t        s1_kind_reg;
    logic [CH_W-1:0]   s1_side_reg;

    logic [PROD_W-1:0] s2_prod_reg;
    post_kind_t        s2_kind_reg;
    logic [CH_W-1:0]   s2_side_reg;

    logic [PROD_W-1:0] s3_y;
    logic [OPND_W-1:0] s3_q0_reg;
    logic [OPND_W:0]   s3_r_reg;
    post_kind_t        s3_kind_reg;
    logic [CH_W-1:0]   s3_side_reg;

    logic [OPND_W-1:0] s4_q;
    logic [CH_W-1:0]   result_next;
    logic [CH_W-1:0]   result_reg;

    // stage 1: operand select, and the side value for subtract and add
    always_comb
    begin
        add_sum      = {5'd0, top} + {1'b0, operand};
        s1_a_next    = top;
        s1_m_next    = {4'd0, bottom};
        s1_kind_next = KIND_SIDE;
        s1_side_next = '0;
        case (mode)
            MODE_MULTIPLY:
            begin
                s1_kind_next = KIND_DIV;
            end
            MODE_SUBTRACT:
            begin
                s1_side_next = (bottom >= top) ? (bottom - top) : '0;
            end
            MODE_SCREEN:
            begin
                s1_a_next    = ~top;
                s1_m_next    = {4'd0, ~bottom};
                s1_kind_next = KIND_INV;
            end
            MODE_OVERLAY:
            begin
                if (bottom[CH_W-1])
                begin
                    s1_a_next    = ~top;
                    s1_m_next    = {3'd0, ~bottom, 1'b0};
                    s1_kind_next = KIND_INV;
                end
                else
                begin
                    s1_m_next    = {3'd0, bottom, 1'b0};
                    s1_kind_next = KIND_DIV;
                end
            end
            MODE_ADD:
            begin
                s1_side_next = (add_sum > {5'd0, CH_MAX}) ? CH_MAX : add_sum[CH_W-1:0];
            end
            MODE_SCALE:
            begin
                s1_m_next    = operand;
                s1_kind_next = KIND_SCALE;
            end
            default:
            begin
                s1_side_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg    <= s1_a_next;
        s1_m_reg    <= s1_m_next;
        s1_kind_reg <= s1_kind_next;
        s1_side_reg <= s1_side_next;
    end

    // stage 2: multiply
    always_ff @(posedge clk)
    begin
        s2_prod_reg <= {{OPND_W{1'b0}}, s1_a_reg} * {{CH_W{1'b0}}, s1_m_reg};
        s2_kind_reg <= s1_kind_reg;
        s2_side_reg <= s1_side_reg;
    end

    // stage 3: rounding bias, quotient estimate y/256 and remainder vs 255
    assign s3_y = s2_prod_reg + ((s2_kind_reg == KIND_SCALE) ? 20'd128 : 20'd127);

    always_ff @(posedge clk)
    begin
        s3_q0_reg   <= s3_y[PROD_W-1:CH_W];
        s3_r_reg    <= {5'd0, s3_y[CH_W-1:0]} + {1'b0, s3_y[PROD_W-1:CH_W]};
        s3_kind_reg <= s2_kind_reg;
        s3_side_reg <= s2_side_reg;
    end

    // stage 4: correct quotient, invert, clamp or pass the side value
    always_comb
    begin
        s4_q = s3_q0_reg
             + {{(OPND_W-1){1'b0}}, (s3_r_reg >= 13'd255)}
             + {{(OPND_W-1){1'b0}}, (s3_r_reg >= 13'd510)};
        case (s3_kind_reg)
            KIND_DIV:   result_next = s4_q[CH_W-1:0];
            KIND_INV:   result_next = CH_MAX - s4_q[CH_W-1:0];
            KIND_SCALE: result_next = (s3_q0_reg > {4'd0, CH_MAX}) ?
                                      CH_MAX : s3_q0_reg[CH_W-1:0];
            default:    result_next = s3_side_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
